// ===== rtl/complex_arith_unit_assert.svh =====
// ----------------------------------------------------------------------------
// complex_arith_unit assertion macros
// Shared assertion forms for the complex ALU; all sample on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH

// same-cycle implication
`define CAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Types, constants and helpers shared by the complex ALU pipeline.
// ----------------------------------------------------------------------------
package cau_pkg;

  typedef enum logic [2:0] {
    ACT_ADD  = 3'd0,
    ACT_SUB  = 3'd1,
    ACT_MUL  = 3'd2,
    ACT_DIV  = 3'd3,
    ACT_LESS = 3'd4,
    ACT_GT   = 3'd5,
    ACT_EQ   = 3'd6
  } action_t;

  localparam int QB   = 17;        // quotient bits produced by the divider
  localparam int RW   = 32 + QB;   // remainder / shifted divisor width
  localparam int NSTG = 3 + QB + 1; // front, divider steps, output stage
  localparam int IN_W  = 72;
  localparam int OUT_W = 40;

  typedef struct packed {
    logic              is_div;
    logic              neg_re;
    logic              neg_im;
    logic signed [15:0] res_real;
    logic signed [15:0] res_imag;
    logic              cmp_true;
    logic              div_zero;
    logic              saturated;
  } meta_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [31:0]   den;
    logic [QB-1:0] quo;
  } lane_t;

  // {clamped flag, 16-bit value}
  function automatic logic [16:0] sat16(input logic signed [33:0] v);
    logic [16:0] r;
    if (v > 34'sd32767)        r = {1'b1, 16'h7FFF};
    else if (v < -34'sd32768)  r = {1'b1, 16'h8000};
    else                       r = {1'b0, v[15:0]};
    return r;
  endfunction

endpackage

// ===== rtl/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// Three stages: products, sums, then finish add/sub/mul/compares and set up
// the divider lanes.
// ----------------------------------------------------------------------------
module cau_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  logic [2:0]           action,
  input  logic signed [15:0]   a_real,
  input  logic signed [15:0]   a_imag,
  input  logic signed [15:0]   b_real,
  input  logic signed [15:0]   b_imag,
  output cau_pkg::meta_t       meta,
  output cau_pkg::lane_t       lane_re,
  output cau_pkg::lane_t       lane_im
);
  import cau_pkg::*;

  localparam logic signed [33:0] BIAS = (34'sd1 <<< FRAC_BITS) - 34'sd1;

  // stage 1
  logic [2:0]         act1_r;
  logic signed [31:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r;
  logic signed [31:0] p_aa_r, p_ab_r, p_bb_r, p_bi_r;
  logic signed [16:0] sre_r, sim_r;
  logic               eq1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      act1_r <= action;
      p_rr_r <= 32'(a_real) * 32'(b_real);
      p_ii_r <= 32'(a_imag) * 32'(b_imag);
      p_ir_r <= 32'(a_imag) * 32'(b_real);
      p_ri_r <= 32'(a_real) * 32'(b_imag);
      p_aa_r <= 32'(a_real) * 32'(a_real);
      p_ab_r <= 32'(a_imag) * 32'(a_imag);
      p_bb_r <= 32'(b_real) * 32'(b_real);
      p_bi_r <= 32'(b_imag) * 32'(b_imag);
      if (action == ACT_SUB) begin
        sre_r <= 17'(a_real) - 17'(b_real);
        sim_r <= 17'(a_imag) - 17'(b_imag);
      end else begin
        sre_r <= 17'(a_real) + 17'(b_real);
        sim_r <= 17'(a_imag) + 17'(b_imag);
      end
      eq1_r <= (a_real == b_real) && (a_imag == b_imag);
    end
  end

  // stage 2
  logic [2:0]         act2_r;
  logic signed [32:0] mre_r, mim_r, dnr_r, dni_r;
  logic [31:0]        den_r, ma_r, mb_r;
  logic signed [16:0] sre2_r, sim2_r;
  logic               eq2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      act2_r <= act1_r;
      mre_r  <= 33'(p_rr_r) - 33'(p_ii_r);
      mim_r  <= 33'(p_ir_r) + 33'(p_ri_r);
      dnr_r  <= 33'(p_rr_r) + 33'(p_ii_r);
      dni_r  <= 33'(p_ir_r) - 33'(p_ri_r);
      den_r  <= $unsigned(p_bb_r) + $unsigned(p_bi_r);
      ma_r   <= $unsigned(p_aa_r) + $unsigned(p_ab_r);
      mb_r   <= $unsigned(p_bb_r) + $unsigned(p_bi_r);
      sre2_r <= sre_r;
      sim2_r <= sim_r;
      eq2_r  <= eq1_r;
    end
  end

  // stage 3
  meta_t meta_nxt;
  lane_t lre_nxt, lim_nxt;
  logic signed [33:0] tre, tim;
  logic signed [32:0] mag_re, mag_im;
  logic [16:0] s_re, s_im;

  always_comb begin
    // truncate toward zero: bias negatives before the arithmetic shift
    tre = (34'(mre_r) + (mre_r < 0 ? BIAS : 34'sd0)) >>> FRAC_BITS;
    tim = (34'(mim_r) + (mim_r < 0 ? BIAS : 34'sd0)) >>> FRAC_BITS;
    mag_re = (dnr_r < 0) ? -dnr_r : dnr_r;
    mag_im = (dni_r < 0) ? -dni_r : dni_r;
    s_re = 17'd0;
    s_im = 17'd0;
    meta_nxt = '0;
    lre_nxt.rem = RW'($unsigned(mag_re)) << FRAC_BITS;
    lre_nxt.den = den_r;
    lre_nxt.quo = '0;
    lim_nxt.rem = RW'($unsigned(mag_im)) << FRAC_BITS;
    lim_nxt.den = den_r;
    lim_nxt.quo = '0;
    case (act2_r)
      ACT_ADD, ACT_SUB: begin
        s_re = sat16(34'(sre2_r));
        s_im = sat16(34'(sim2_r));
      end
      ACT_MUL: begin
        s_re = sat16(tre);
        s_im = sat16(tim);
      end
      ACT_DIV: begin
        meta_nxt.is_div   = (den_r != 32'd0);
        meta_nxt.div_zero = (den_r == 32'd0);
        meta_nxt.neg_re   = dnr_r < 0;
        meta_nxt.neg_im   = dni_r < 0;
      end
      ACT_LESS: meta_nxt.cmp_true = ma_r < mb_r;
      ACT_GT:   meta_nxt.cmp_true = ma_r > mb_r;
      ACT_EQ:   meta_nxt.cmp_true = eq2_r;
      default: ;
    endcase
    meta_nxt.res_real  = s_re[15:0];
    meta_nxt.res_imag  = s_im[15:0];
    meta_nxt.saturated = s_re[16] | s_im[16];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      meta    <= meta_nxt;
      lane_re <= lre_nxt;
      lane_im <= lim_nxt;
    end
  end

endmodule

// ===== rtl/cau_div_step.sv =====
// ----------------------------------------------------------------------------
// cau_div_step
// One restoring-division stage: decides quotient bit BIT for both lanes.
// ----------------------------------------------------------------------------
module cau_div_step #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           en,
  input  cau_pkg::meta_t meta_in,
  input  cau_pkg::lane_t lre_in,
  input  cau_pkg::lane_t lim_in,
  output cau_pkg::meta_t meta_out,
  output cau_pkg::lane_t lre_out,
  output cau_pkg::lane_t lim_out
);
  import cau_pkg::*;

  lane_t lre_nxt, lim_nxt;
  logic [RW-1:0] dsh;

  always_comb begin
    dsh = RW'(lre_in.den) << BIT;
    lre_nxt = lre_in;
    lim_nxt = lim_in;
    if (lre_in.rem >= dsh) begin
      lre_nxt.rem      = lre_in.rem - dsh;
      lre_nxt.quo[BIT] = 1'b1;
    end
    if (lim_in.rem >= dsh) begin
      lim_nxt.rem      = lim_in.rem - dsh;
      lim_nxt.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_out <= meta_in;
      lre_out  <= lre_nxt;
      lim_out  <= lim_nxt;
    end
  end

endmodule

// ===== rtl/cau_out.sv =====
// ----------------------------------------------------------------------------
// cau_out
// Output register: signs and clamps the quotients, packs the result word.
// ----------------------------------------------------------------------------
module cau_out (
  input  logic                       clk,
  input  logic                       en,
  input  cau_pkg::meta_t             meta,
  input  cau_pkg::lane_t             lane_re,
  input  cau_pkg::lane_t             lane_im,
  output logic [cau_pkg::OUT_W-1:0]  tdata
);
  import cau_pkg::*;

  logic [OUT_W-1:0] tdata_r, tdata_nxt;

  function automatic logic signed [33:0] signed_quo(input lane_t l, input logic neg);
    logic signed [33:0] m;
    // a remainder still at or above the divisor means the quotient overflowed
    if (l.rem >= RW'(l.den)) m = 34'sd1 <<< QB;
    else                     m = 34'(l.quo);
    return neg ? -m : m;
  endfunction

  logic [16:0] q_re, q_im;

  always_comb begin
    q_re = sat16(signed_quo(lane_re, meta.neg_re));
    q_im = sat16(signed_quo(lane_im, meta.neg_im));
    if (meta.is_div) begin
      tdata_nxt = {5'd0, q_re[16] | q_im[16], 1'b0, 1'b0, q_im[15:0], q_re[15:0]};
    end else begin
      tdata_nxt = {5'd0, meta.saturated, meta.div_zero, meta.cmp_true,
                   meta.res_imag, meta.res_real};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tdata_r <= tdata_nxt;
    end
  end

  assign tdata = tdata_r;

endmodule

// ===== rtl/complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit
// Pipelined complex ALU on signed Q8.8 operands.
// ----------------------------------------------------------------------------
// Input stream: one request per in_tvalid & in_tready carries the action and
// both complex operands. Output stream: one result per request, in order,
// with real/imag parts, compare outcome, divide-by-zero and clamp flags.
// From acceptance to out_tvalid a request passes 21 register stages, the
// first loaded at the accepting edge: 3 front stages (products, sums,
// finish/setup), 17 restoring-division stages (one quotient bit each, both
// parts in parallel) and the output register. Every action takes the same
// path, so throughput is one request per cycle unless out_tready stalls it.
// Each stage has its own valid bit and loads when it is empty or the stage
// after it moves, so bubbles close up and in_tready stays high while the
// pipe has room even if a result waits at the output.
// When the receiver holds out_tready low the output and filled stages hold;
// nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers
// are not reset.
// ----------------------------------------------------------------------------
`include "complex_arith_unit_assert.svh"

module complex_arith_unit #(
  parameter int FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // action[2:0], a_real[18:3], a_imag[34:19], b_real[50:35], b_imag[66:51]
  input  logic [cau_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // res_real[15:0], res_imag[31:16], cmp_true[32], div_zero[33], saturated[34]
  output logic [cau_pkg::OUT_W-1:0] out_tdata
);
  import cau_pkg::*;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_tvalid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NSTG-1];

  meta_t meta_s [QB+1];
  lane_t lre_s  [QB+1];
  lane_t lim_s  [QB+1];

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk     (clk),
    .en      (en[2:0]),
    .action  (in_tdata[2:0]),
    .a_real  (in_tdata[18:3]),
    .a_imag  (in_tdata[34:19]),
    .b_real  (in_tdata[50:35]),
    .b_imag  (in_tdata[66:51]),
    .meta    (meta_s[0]),
    .lane_re (lre_s[0]),
    .lane_im (lim_s[0])
  );

  // quotient bits from the top down
  for (genvar j = 0; j < QB; j++) begin : g_div
    cau_div_step #(.BIT(QB - 1 - j)) u_step (
      .clk      (clk),
      .en       (en[3+j]),
      .meta_in  (meta_s[j]),
      .lre_in   (lre_s[j]),
      .lim_in   (lim_s[j]),
      .meta_out (meta_s[j+1]),
      .lre_out  (lre_s[j+1]),
      .lim_out  (lim_s[j+1])
    );
  end

  cau_out u_out (
    .clk     (clk),
    .en      (en[NSTG-1]),
    .meta    (meta_s[QB]),
    .lane_re (lre_s[QB]),
    .lane_im (lim_s[QB]),
    .tdata   (out_tdata)
  );

  `CAU_ASSERT_NOW(a_ready_when_empty, !v_r[0], in_tready, "entry stage empty but not ready")
  `CAU_ASSERT_NEXT(a_accept_fills, in_tvalid && in_tready, v_r[0], "accepted request lost")
  `CAU_ASSERT_NOW(a_divzero_clean, out_tvalid && out_tdata[33],
    out_tdata[31:0] == 32'd0 && !out_tdata[34] && !out_tdata[32], "div-by-zero result not zero")

endmodule

// ===== bench/complex_arith_unit_test.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit_test
// Streams directed and random complex ALU requests through the pipeline under
// three idling patterns and checks every result against an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_arith_unit_test;
  import cau_pkg::*;

  localparam int FRAC = 8;
  localparam int LATENCY = 21;

  typedef struct packed {
    logic signed [15:0] b_imag;
    logic signed [15:0] b_real;
    logic signed [15:0] a_imag;
    logic signed [15:0] a_real;
    logic [2:0]         action;
  } request_t;

  typedef struct packed {
    logic               saturated;
    logic               div_zero;
    logic               cmp_true;
    logic signed [15:0] res_imag;
    logic signed [15:0] res_real;
  } result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;
  // handshake seen at the last rising edge
  logic in_tready_seen;

  request_t pending_reqs[$];
  result_t  expected_results[$];
  int errors;
  int n_sent;
  int n_checked;
  int send_idle_pct;
  int recv_idle_pct;

  complex_arith_unit #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  function automatic logic signed [15:0] clamp_part(input longint v, inout logic sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'sh7FFF;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // SV division truncates toward zero, as the arithmetic requires
  function automatic result_t complex_result(input request_t r);
    longint ar, ai, br, bi, re, im, den, ma, mb;
    logic sat;
    result_t o;
    ar = r.a_real;
    ai = r.a_imag;
    br = r.b_real;
    bi = r.b_imag;
    re = 0;
    im = 0;
    sat = 1'b0;
    o = '0;
    case (r.action)
      ACT_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      ACT_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      ACT_MUL: begin
        re = (ar * br - ai * bi) / (64'sd1 << FRAC);
        im = (ai * br + ar * bi) / (64'sd1 << FRAC);
      end
      ACT_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          o.div_zero = 1'b1;
        end else begin
          re = ((ar * br + ai * bi) * (64'sd1 << FRAC)) / den;
          im = ((ai * br - ar * bi) * (64'sd1 << FRAC)) / den;
        end
      end
      ACT_LESS, ACT_GT: begin
        ma = ar * ar + ai * ai;
        mb = br * br + bi * bi;
        o.cmp_true = (r.action == ACT_LESS) ? (ma < mb) : (ma > mb);
      end
      ACT_EQ: o.cmp_true = (ar == br) && (ai == bi);
      default: ;
    endcase
    o.res_real = clamp_part(re, sat);
    o.res_imag = clamp_part(im, sat);
    o.saturated = sat;
    return o;
  endfunction

  function automatic logic [15:0] operand_value();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_req(input logic [2:0] act, input logic [15:0] ar, input logic [15:0] ai,
                           input logic [15:0] br, input logic [15:0] bi);
    request_t r;
    r.action = act;
    r.a_real = ar;
    r.a_imag = ai;
    r.b_real = br;
    r.b_imag = bi;
    pending_reqs.push_back(r);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready_seen) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tdata <= {5'b0, pending_reqs.pop_front()};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_tready_seen <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      expected_results.push_back(complex_result(request_t'(in_tdata[66:0])));
      n_sent <= n_sent + 1;
    end
  end

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    result_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[34:0];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors <= errors + 1;
      end else begin
        exp_r = expected_results.pop_front();
        n_checked <= n_checked + 1;
        if (got.res_real !== exp_r.res_real || got.res_imag !== exp_r.res_imag ||
            got.cmp_true !== exp_r.cmp_true || got.div_zero !== exp_r.div_zero ||
            got.saturated !== exp_r.saturated) begin
          $display("%0t: mismatch expected re=%h im=%h cmp=%b dz=%b sat=%b", $time,
                   exp_r.res_real, exp_r.res_imag, exp_r.cmp_true, exp_r.div_zero,
                   exp_r.saturated);
          $display("%0t:          actual   re=%h im=%h cmp=%b dz=%b sat=%b", $time,
                   got.res_real, got.res_imag, got.cmp_true, got.div_zero, got.saturated);
          errors <= errors + 1;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("complex_arith_unit_test failed");
    $finish;
  end

  initial begin
    int k;
    logic [2:0] act;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    in_tready_seen = 1'b0;
    send_idle_pct = 15;
    recv_idle_pct = 51;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: every action at the extremes, zero divisor, unused code
    for (int a = 0; a < 7; a++) begin
      queue_req(a[2:0], 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      queue_req(a[2:0], 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
    end
    queue_req(ACT_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
    queue_req(ACT_DIV, 16'h8000, 16'h8000, 16'h0001, 16'h0000);
    queue_req(ACT_DIV, 16'hFF00, 16'h0080, 16'h0100, 16'hFF00);
    queue_req(ACT_MUL, 16'hFFFF, 16'h0001, 16'h0001, 16'h0001);
    queue_req(ACT_EQ, 16'h1234, 16'hABCD, 16'h1234, 16'hABCD);
    queue_req(ACT_LESS, 16'h0300, 16'h0400, 16'h0500, 16'h0000);
    queue_req(ACT_GT, 16'h0500, 16'h0000, 16'hFB00, 16'h0000);
    queue_req(3'd7, 16'h1111, 16'h2222, 16'h3333, 16'h4444);

    for (int phase = 0; phase < 3; phase++) begin
      for (k = 0; k < 317; k++) begin
        act = 3'($urandom_range(0, 7));
        if (act == 3'd7 && $urandom_range(0, 3) != 0) act = ACT_DIV;
        if (act == ACT_EQ && $urandom_range(0, 1)) begin
          logic [15:0] x, y;
          x = operand_value();
          y = operand_value();
          queue_req(act, x, y, x, y);
        end else if (act == ACT_DIV && $urandom_range(0, 15) == 0) begin
          queue_req(act, operand_value(), operand_value(), 16'h0000, 16'h0000);
        end else begin
          queue_req(act, operand_value(), operand_value(), operand_value(), operand_value());
        end
      end
      while (pending_reqs.size() > 0) @(posedge clk);
      if (phase == 0) begin
        send_idle_pct = 51;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end

    while (expected_results.size() > 0 || in_tvalid) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d requests over all seven actions and the unused code;", n_sent);
    $display("checked %0d results under three idling patterns.", n_checked);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("complex_arith_unit_test passed");
    end else begin
      $display("complex_arith_unit_test failed");
    end
    $finish;
  end

endmodule
